@@ rtl/core/hfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_pkg
// Shared types, codes and small tables for the H4 frame splitter.
// ----------------------------------------------------------------------------
package hfs_pkg;

	localparam int MaxPacketBytes = 4096;
	localparam int PosW           = $clog2(MaxPacketBytes);
	localparam logic [PosW-1:0] LastPos = PosW'(MaxPacketBytes - 1);

	localparam logic [15:0] IsoLenMask = 16'h3fff;

	// indicator bytes
	localparam logic [7:0] IndEvt = 8'h04;
	localparam logic [7:0] IndAcl = 8'h02;
	localparam logic [7:0] IndSco = 8'h03;
	localparam logic [7:0] IndIso = 8'h05;

	// configuration register indexes
	localparam logic [1:0] RegLinkHdr = 2'd0;
	localparam logic [1:0] RegOpen    = 2'd1;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_NEXT,
		PH_HEAD,
		PH_BODY,
		PH_DROP
	} phase_t;

	typedef enum logic [1:0] {
		FK_EVT,
		FK_ACL,
		FK_SCO,
		FK_ISO
	} frame_kind_t;

	typedef enum logic [1:0] {
		RES_FRAME,
		RES_UNKNOWN,
		RES_TRUNC,
		RES_RUNT
	} res_kind_t;

	typedef enum logic [1:0] {
		BUF_EVT,
		BUF_ACL,
		BUF_ISO
	} buf_type_t;

	typedef struct packed {
		logic            has;
		res_kind_t       kind;
		buf_type_t       btype;
		logic [11:0]     offset;
		logic [11:0]     plen;
	} result_t;

	function automatic logic [2:0] hdr_len(input frame_kind_t fk);
		logic [2:0] n;
		case (fk)
			FK_EVT:  n = 3'd2;
			FK_ACL:  n = 3'd4;
			FK_SCO:  n = 3'd3;
			FK_ISO:  n = 3'd4;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

	// sco goes to the event buffer
	function automatic buf_type_t buf_of(input frame_kind_t fk);
		buf_type_t t;
		case (fk)
			FK_ACL:  t = BUF_ACL;
			FK_ISO:  t = BUF_ISO;
			default: t = BUF_EVT;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/core/hfs_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_parse
// Per-byte parse state and result decode for the H4 frame splitter.
// ----------------------------------------------------------------------------
module hfs_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             packet_end,
	input  logic [3:0]       link_header_bytes,
	input  logic             transport_open,
	output hfs_pkg::result_t res
);
	import hfs_pkg::*;

	phase_t          phase_q, phase_n;
	logic [PosW-1:0] pos_q, pos_n;
	frame_kind_t     fk_q, fk_n;
	logic [2:0]      hidx_q, hidx_n;
	logic [15:0]     pl_q, pl_n;
	logic [11:0]     fstart_q, fstart_n;
	logic [3:0]      skip_q, skip_n;

	logic            last;
	logic            skip_hold;
	logic            first;
	logic [11:0]     off;
	logic            known;
	frame_kind_t     ind_kind;
	logic [15:0]     pl_head;
	logic [2:0]      hidx_inc;
	logic            hdr_done;
	logic [15:0]     pl_dec;
	logic            done;

	assign last      = packet_end || (pos_q == LastPos);
	assign skip_hold = (phase_q == PH_SKIP) && (pos_q < {{(PosW-4){1'b0}}, link_header_bytes});
	assign first     = (phase_q == PH_SKIP) && !skip_hold;
	assign off       = first ? 12'd0 : 12'(pos_q - {{(PosW-4){1'b0}}, skip_q});

	always_comb begin
		known    = 1'b1;
		ind_kind = FK_EVT;
		case (data_byte)
			IndEvt:  ind_kind = FK_EVT;
			IndAcl:  ind_kind = FK_ACL;
			IndSco:  ind_kind = FK_SCO;
			IndIso:  ind_kind = FK_ISO;
			default: known = 1'b0;
		endcase
	end

	// length field capture while walking the frame header
	always_comb begin
		pl_head = pl_q;
		if (fk_q == FK_EVT && hidx_q == 3'd1) begin
			pl_head = {8'd0, data_byte};
		end else if (hidx_q == 3'd2 && fk_q != FK_EVT) begin
			pl_head = {8'd0, data_byte};
		end else if ((fk_q == FK_ACL || fk_q == FK_ISO) && hidx_q == 3'd3) begin
			pl_head = pl_q | {data_byte, 8'd0};
			if (fk_q == FK_ISO) begin
				pl_head = pl_head & IsoLenMask;
			end
		end
	end

	assign hidx_inc = hidx_q + 3'd1;
	assign hdr_done = hidx_inc >= hdr_len(fk_q);
	assign pl_dec   = pl_q - 16'd1;
	assign done     = ((phase_q == PH_HEAD) && hdr_done && (pl_head == 16'd0))
	               || ((phase_q == PH_BODY) && (pl_dec == 16'd0));

	// next state
	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q;
		fk_n     = fk_q;
		hidx_n   = hidx_q;
		pl_n     = pl_q;
		fstart_n = fstart_q;
		skip_n   = skip_q;
		if (phase_q == PH_DROP) begin
			if (packet_end) begin
				phase_n = PH_SKIP;
			end
		end else begin
			pos_n = pos_q + PosW'(1);
			if (skip_hold) begin
				if (last) begin
					phase_n = packet_end ? PH_SKIP : PH_DROP;
					pos_n   = '0;
				end
			end else if (phase_q == PH_SKIP || phase_q == PH_NEXT) begin
				if (first) begin
					skip_n = pos_q[3:0];
				end
				if ((!first && data_byte == 8'd0) || !known || last) begin
					phase_n = packet_end ? PH_SKIP : PH_DROP;
					pos_n   = '0;
				end else begin
					phase_n = PH_HEAD;
				end
				if (known) begin
					fk_n     = ind_kind;
					fstart_n = off;
					hidx_n   = 3'd0;
					pl_n     = 16'd0;
				end
			end else begin
				if (phase_q == PH_HEAD) begin
					pl_n   = pl_head;
					hidx_n = hidx_inc;
					if (hdr_done && pl_head != 16'd0) begin
						phase_n = PH_BODY;
					end
				end else begin
					pl_n = pl_dec;
				end
				if (last) begin
					phase_n = packet_end ? PH_SKIP : PH_DROP;
					pos_n   = '0;
				end else if (done) begin
					phase_n = PH_NEXT;
				end
			end
		end
	end

	// result decode
	always_comb begin
		res        = '0;
		res.kind   = RES_FRAME;
		res.btype  = BUF_EVT;
		case (phase_q)
			PH_DROP: res.has = 1'b0;
			PH_SKIP, PH_NEXT: begin
				if (skip_hold) begin
					res.has  = last;
					res.kind = RES_RUNT;
				end else if (!first && data_byte == 8'd0) begin
					res.has = 1'b0;
				end else if (!known) begin
					res.has    = 1'b1;
					res.kind   = RES_UNKNOWN;
					res.offset = off;
				end else if (last) begin
					res.has    = 1'b1;
					res.kind   = RES_TRUNC;
					res.offset = off;
				end
			end
			PH_HEAD, PH_BODY: begin
				if (done) begin
					res.has    = transport_open;
					res.kind   = RES_FRAME;
					res.btype  = buf_of(fk_q);
					res.offset = fstart_q;
					res.plen   = off - fstart_q;
				end else if (last) begin
					res.has    = 1'b1;
					res.kind   = RES_TRUNC;
					res.offset = fstart_q;
				end
			end
			default: res.has = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			pos_q    <= '0;
			fk_q     <= FK_EVT;
			hidx_q   <= '0;
			pl_q     <= '0;
			fstart_q <= '0;
			skip_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			pos_q    <= pos_n;
			fk_q     <= fk_n;
			hidx_q   <= hidx_n;
			pl_q     <= pl_n;
			fstart_q <= fstart_n;
			skip_q   <= skip_n;
		end
	end

endmodule

@@ rtl/core/hci_h4_frame_splitter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_h4_frame_splitter_top
// Splits H4 frames out of channel packets, one packet byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries packet bytes; s_tlast marks the last byte of a packet.
//   m_* carries one report per completed frame (only while the transport
//   is open) or per error: unknown indicator, truncated frame, runt packet.
//   cfg_* writes register 0 (link header length, reset 4) or register 1
//   (transport open, reset 0); other indexes are ignored. Write only while
//   the block is idle.
// Timing:
//   a byte is registered on input, parsed combinationally from that register and
//   its report, if any, is registered into the output register that drives m_*.
//   one byte per cycle is sustained while no report waits on m_tready; the
//   parse step between the input register and the report register is combinational.
// Reset:
//   arst_n clears the parse state to the start of a packet and the
//   registers to their reset values; no report is pending.
// Stall:
//   while m_tready is low a pending report holds; bytes that give no report
//   keep flowing, and the input stalls at the first byte that would report.
// ----------------------------------------------------------------------------
module hci_h4_frame_splitter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // packet_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // frame_offset[11:0], payload_length[23:12]
	output logic [3:0]  m_tuser,   // kind[1:0], buffer_type[3:2]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import hfs_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic [3:0]  link_hdr_q;
	logic        open_q;
	logic        out_valid_q;
	res_kind_t   kind_q;
	buf_type_t   btype_q;
	logic [11:0] offset_q;
	logic [11:0] plen_q;
	result_t     res;
	logic        out_free;
	logic        adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_hdr_q <= 4'd4;
			open_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == RegLinkHdr) begin
				link_hdr_q <= cfg_data;
			end else if (cfg_index == RegOpen) begin
				open_q <= cfg_data[0];
			end
		end
	end

	hfs_parse u_parse (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (adv),
		.data_byte         (byte_s1),
		.packet_end        (end_s1),
		.link_header_bytes (link_hdr_q),
		.transport_open    (open_q),
		.res               (res)
	);

	// a byte without a report never waits on the output side
	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (!res.has || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res.has;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.has) begin
			kind_q   <= res.kind;
			btype_q  <= res.btype;
			offset_q <= res.offset;
			plen_q   <= res.plen;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {plen_q, offset_q};
	assign m_tuser  = {btype_q, kind_q};

	a_runt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind_q == RES_RUNT) |-> (offset_q == 12'd0 && plen_q == 12'd0))
		else $error("runt report with nonzero fields");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind_q != RES_FRAME) |-> (btype_q == BUF_EVT && plen_q == 12'd0))
		else $error("error report with frame fields set");

	a_closed_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.has && !open_q) |-> (res.kind != RES_FRAME))
		else $error("frame reported while transport closed");

	a_hold_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(byte_s1) && $stable(end_s1)))
		else $error("stalled byte lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("pending report overwritten");

endmodule
